// ----- src/ldwc_pkg.sv -----
package ldwc_pkg;

    // Default map depth and the hard cap on the half window
    localparam int MAX_MARKERS_DEF = 65536;
    localparam int MAX_HALF_WINDOW = 1024;

    // Field widths
    localparam int MARKER_W    = 16;
    localparam int P_W         = 32;
    localparam int OFFSET_W    = 12;
    localparam int CORR_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int HW_W        = 11;
    localparam int R2_W        = 31;
    localparam int TOTAL_W     = 17;
    localparam int K_W         = 19;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 24;

    // Item kinds carried on tuser
    localparam logic OP_CORR  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_NEW        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SUPPRESSED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_P_HIGH     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_WINDOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_P_LIMIT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_R2_LIMIT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_TOTAL = 2'd3;

    // Configuration reset values
    localparam logic [HW_W-1:0]    HALF_WINDOW_RST  = 11'd100;
    localparam logic [P_W-1:0]     P_LIMIT_RST      = 32'h3D4C_CCCD;
    localparam logic [R2_W-1:0]    R2_LIMIT_RST     = 31'd107374182;
    localparam logic [TOTAL_W-1:0] MARKER_TOTAL_RST = 17'd65536;

    // One row element after the front stage
    typedef struct packed {
        logic                start;
        logic [MARKER_W-1:0] marker;
        logic                in_range;
        logic                p_ok;
        logic                k_ok;
        logic [R2_W-1:0]     sq;
        logic                last;
    } row_item_t;

endpackage

// ----- src/ldwc_ram.sv -----
module ldwc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the contents from before a same-cycle write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ldwc_front.sv -----
module ldwc_front #(
    parameter int MAX_MARKERS = ldwc_pkg::MAX_MARKERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              data_accept,
    input  logic                              clear_accept,
    input  logic                              b_fire,
    input  logic [ldwc_pkg::MARKER_W-1:0]     marker_index,
    input  logic [ldwc_pkg::P_W-1:0]          p_value,
    input  logic [ldwc_pkg::OFFSET_W-1:0]     window_offset,
    input  logic signed [ldwc_pkg::CORR_W-1:0] correlation,
    input  logic                              last_of_row,
    input  logic [ldwc_pkg::HW_W-1:0]         hw_eff,
    input  logic [ldwc_pkg::TOTAL_W-1:0]      total_eff,
    input  logic [ldwc_pkg::P_W-1:0]          p_limit,
    output logic [$clog2(MAX_MARKERS)-1:0]    rd_addr,
    output ldwc_pkg::row_item_t               item,
    output logic [$clog2(MAX_MARKERS)-1:0]    k_addr,
    output logic                              b_valid
);

    import ldwc_pkg::*;

    localparam int AW = $clog2(MAX_MARKERS);

    logic                row_open_reg, row_open_next;
    logic [MARKER_W-1:0] row_marker_reg, row_marker_next;
    logic                b_valid_reg, b_valid_next;
    row_item_t           item_reg;
    logic [AW-1:0]       k_addr_reg;

    logic                start;
    logic [MARKER_W-1:0] row_m;
    logic signed [K_W-1:0] k;
    logic [OFFSET_W-1:0] twice_hw;
    logic signed [2*CORR_W-1:0] prod;
    logic [AW+MARKER_W-1:0] m_wide;
    logic [AW+K_W-2:0]   k_wide;
    row_item_t           item_next;

    assign start    = !row_open_reg;
    assign row_m    = start ? marker_index : row_marker_reg;
    assign k        = $signed({3'b000, row_m}) - $signed({8'h00, hw_eff})
                    + $signed({7'h00, window_offset});
    assign twice_hw = {hw_eff, 1'b0};
    assign prod     = correlation * correlation;

    assign m_wide  = {{AW{1'b0}}, marker_index};
    assign rd_addr = m_wide[AW-1:0];
    assign k_wide  = {{AW{1'b0}}, k[K_W-2:0]};

    always_comb
    begin
        item_next.start    = start;
        item_next.marker   = row_m;
        item_next.in_range = {1'b0, marker_index} < total_eff;
        item_next.p_ok     = p_value < p_limit;
        item_next.k_ok     = (window_offset <= twice_hw) && !k[K_W-1]
                           && (k[K_W-2:0] < {1'b0, total_eff})
                           && (k[K_W-2:0] != {2'b00, row_m});
        item_next.sq       = prod[R2_W-1:0];
        item_next.last     = last_of_row;
    end

    always_comb
    begin
        row_open_next   = row_open_reg;
        row_marker_next = row_marker_reg;
        if (clear_accept)
        begin
            row_open_next = 1'b0;
        end
        else if (data_accept)
        begin
            row_open_next = !last_of_row;
            if (start)
            begin
                row_marker_next = marker_index;
            end
        end
        b_valid_next = data_accept ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_open_reg   <= 1'b0;
            row_marker_reg <= '0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            row_open_reg   <= row_open_next;
            row_marker_reg <= row_marker_next;
            b_valid_reg    <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_accept)
        begin
            item_reg   <= item_next;
            k_addr_reg <= k_wide[AW-1:0];
        end
    end

    assign item    = item_reg;
    assign k_addr  = k_addr_reg;
    assign b_valid = b_valid_reg;

endmodule

// ----- src/ldwc_decide.sv -----
module ldwc_decide #(
    parameter int MAX_MARKERS = ldwc_pkg::MAX_MARKERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           b_valid,
    input  ldwc_pkg::row_item_t            item,
    input  logic [$clog2(MAX_MARKERS)-1:0] k_addr,
    input  logic                           sup_rd,
    input  logic                           sel_rd,
    input  logic [ldwc_pkg::R2_W-1:0]      r2_limit,
    input  logic                           data_accept,
    input  logic                           clear_accept,
    input  logic [$clog2(MAX_MARKERS)-1:0] rd_addr,
    output logic                           b_fire,
    output logic                           sup_we,
    output logic [$clog2(MAX_MARKERS)-1:0] sup_waddr,
    output logic                           sel_we,
    output logic [$clog2(MAX_MARKERS)-1:0] sel_waddr,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [ldwc_pkg::M_TDATA_W-1:0] m_tdata
);

    import ldwc_pkg::*;

    localparam int AW = $clog2(MAX_MARKERS);

    logic                row_taken_reg, row_taken_next;
    logic [STATUS_W-1:0] row_status_reg, row_status_next;
    logic                fwd_sup_reg, fwd_sup_next;
    logic                fwd_sel_reg, fwd_sel_next;
    logic                out_valid_reg, out_valid_next;
    logic [MARKER_W-1:0] out_marker_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                sup_bit, sel_bit;
    logic [STATUS_W-1:0] start_status, status_now;
    logic                taken_now;
    logic [AW+MARKER_W-1:0] m_wide;

    assign sup_bit = sup_rd | fwd_sup_reg;
    assign sel_bit = sel_rd | fwd_sel_reg;

    always_comb
    begin
        priority if (!item.in_range)
        begin
            start_status = STATUS_P_HIGH;
        end
        else if (sup_bit)
        begin
            start_status = STATUS_SUPPRESSED;
        end
        else if (sel_bit)
        begin
            start_status = STATUS_ALREADY;
        end
        else if (!item.p_ok)
        begin
            start_status = STATUS_P_HIGH;
        end
        else
        begin
            start_status = STATUS_NEW;
        end
    end

    assign status_now = item.start ? start_status : row_status_reg;
    assign taken_now  = item.start ? (start_status == STATUS_NEW) : row_taken_reg;

    // A row end waits for room in the output register
    assign b_fire = b_valid && (!item.last || !out_valid_reg || m_tready);

    assign m_wide    = {{AW{1'b0}}, item.marker};
    assign sel_we    = b_fire && item.start && (start_status == STATUS_NEW);
    assign sel_waddr = m_wide[AW-1:0];
    assign sup_we    = b_fire && taken_now && item.k_ok && (item.sq >= r2_limit);
    assign sup_waddr = k_addr;

    always_comb
    begin
        row_taken_next  = row_taken_reg;
        row_status_next = row_status_reg;
        fwd_sup_next    = fwd_sup_reg;
        fwd_sel_next    = fwd_sel_reg;
        if (b_fire)
        begin
            row_taken_next  = item.last ? 1'b0 : taken_now;
            row_status_next = status_now;
        end
        if (clear_accept)
        begin
            row_taken_next = 1'b0;
        end
        // The map read of the entering item misses a write landing at the same edge
        if (data_accept)
        begin
            fwd_sup_next = sup_we && (sup_waddr == rd_addr);
            fwd_sel_next = sel_we && (sel_waddr == rd_addr);
        end
        out_valid_next = (b_fire && item.last) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_taken_reg  <= 1'b0;
            row_status_reg <= STATUS_NEW;
            fwd_sup_reg    <= 1'b0;
            fwd_sel_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            row_taken_reg  <= row_taken_next;
            row_status_reg <= row_status_next;
            fwd_sup_reg    <= fwd_sup_next;
            fwd_sel_reg    <= fwd_sel_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && item.last)
        begin
            out_marker_reg <= item.marker;
            out_status_reg <= status_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-MARKER_W-STATUS_W){1'b0}}, out_status_reg, out_marker_reg};

endmodule

// ----- src/ld_window_clumping.sv -----
// Greedy linkage-disequilibrium clumping over a stream of correlation rows. Send
// markers in priority order; each marker's row is a run of elements, one per
// neighbor from marker - half_window to marker + half_window, the last one
// flagged by s_tlast, and the marker index and p-value are taken from the first
// element of the row only. A row whose marker is free and has a p-value below
// p_limit selects the marker and suppresses every neighbor whose squared
// correlation reaches r2_limit; at the row's last element one result gives the
// marker and its status (0 newly selected, 1 suppressed, 2 already selected,
// 3 p-value not below the limit or marker out of range). The selected and
// suppressed maps live in two one-bit-wide synchronous RAMs of MAX_MARKERS
// entries, read at the row start and written back one stage later, with a
// forwarding path for a write that lands in the same cycle as the next read.
// The block takes one element per clock unless a row end waits on the result
// register. After reset and every clear request (tuser high) it sweeps both maps
// to zero, one entry a cycle, with s_tready low until done; configuration writes
// are taken at any time but belong between rows while the block is idle.
module ld_window_clumping #(
    parameter int MAX_MARKERS = ldwc_pkg::MAX_MARKERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Element requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // marker_index [15:0], p_value [47:16], window_offset [59:48],
    // correlation [75:60], zero fill [79:76]
    input  logic [ldwc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,   // last_of_row
    input  logic                              s_tuser,   // opcode
    // Result requests
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_marker [15:0], status [17:16], zero fill [23:18]
    output logic [ldwc_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ldwc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ldwc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import ldwc_pkg::*;

    localparam int AW = $clog2(MAX_MARKERS);
    localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_MARKERS - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_CAP =
        (MAX_MARKERS > 131071) ? 17'h1FFFF : TOTAL_W'(MAX_MARKERS);
    localparam logic [HW_W-1:0] HW_CAP =
        (MAX_HALF_WINDOW > 2047) ? 11'h7FF : HW_W'(MAX_HALF_WINDOW);

    typedef enum logic [1:0] {
        ST_SWEEP = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       sweep_cnt_reg, sweep_cnt_next;

    logic [HW_W-1:0]     half_window_reg, half_window_next;
    logic [P_W-1:0]      p_limit_reg, p_limit_next;
    logic [R2_W-1:0]     r2_limit_reg, r2_limit_next;
    logic [TOTAL_W-1:0]  marker_total_reg, marker_total_next;

    logic [HW_W-1:0]     hw_eff;
    logic [TOTAL_W-1:0]  total_eff;

    logic                sweeping;
    logic                accept;
    logic                data_accept;
    logic                clear_accept;
    logic                b_fire;
    logic                b_valid;
    row_item_t           item;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       k_addr;

    logic                sup_we, sel_we;
    logic [AW-1:0]       sup_waddr, sel_waddr;
    logic                sup_rd, sel_rd;
    logic                sup_ram_we, sel_ram_we;
    logic [AW-1:0]       sup_ram_waddr, sel_ram_waddr;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        half_window_next  = half_window_reg;
        p_limit_next      = p_limit_reg;
        r2_limit_next     = r2_limit_reg;
        marker_total_next = marker_total_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HALF_WINDOW:  half_window_next  = cfg_data[HW_W-1:0];
                CFG_P_LIMIT:      p_limit_next      = cfg_data[P_W-1:0];
                CFG_R2_LIMIT:     r2_limit_next     = cfg_data[R2_W-1:0];
                CFG_MARKER_TOTAL: marker_total_next = cfg_data[TOTAL_W-1:0];
            endcase
        end
    end

    // Clamp the window to MAX_HALF_WINDOW and the marker count to what the maps can hold
    assign hw_eff    = (half_window_reg < HW_CAP) ? half_window_reg : HW_CAP;
    assign total_eff = (marker_total_reg < TOTAL_CAP) ? marker_total_reg : TOTAL_CAP;

    // ---------------------------------------------------------------
    // Input handshake: stall while sweeping or while a row end waits
    // ---------------------------------------------------------------
    assign sweeping     = (state_reg == ST_SWEEP);
    assign s_tready     = !sweeping && (!b_valid || b_fire);
    assign accept       = s_tvalid && s_tready;
    assign data_accept  = accept && (s_tuser == OP_CORR);
    assign clear_accept = accept && (s_tuser == OP_CLEAR);

    // ---------------------------------------------------------------
    // Map sweep sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    sweep_cnt_next = '0;
                    state_next     = ST_RUN;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + AW'(1);
                end
            end
            ST_RUN:
            begin
                if (clear_accept)
                begin
                    state_next = ST_SWEEP;
                end
            end
            default:
            begin
                state_next     = ST_SWEEP;
                sweep_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SWEEP;
            sweep_cnt_reg    <= '0;
            half_window_reg  <= HALF_WINDOW_RST;
            p_limit_reg      <= P_LIMIT_RST;
            r2_limit_reg     <= R2_LIMIT_RST;
            marker_total_reg <= MARKER_TOTAL_RST;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            half_window_reg  <= half_window_next;
            p_limit_reg      <= p_limit_next;
            r2_limit_reg     <= r2_limit_next;
            marker_total_reg <= marker_total_next;
        end
    end

    // ---------------------------------------------------------------
    // Front stage: row tracking, neighbor index, square
    // ---------------------------------------------------------------
    ldwc_front #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_accept   (data_accept),
        .clear_accept  (clear_accept),
        .b_fire        (b_fire),
        .marker_index  (s_tdata[15:0]),
        .p_value       (s_tdata[47:16]),
        .window_offset (s_tdata[59:48]),
        .correlation   (s_tdata[75:60]),
        .last_of_row   (s_tlast),
        .hw_eff        (hw_eff),
        .total_eff     (total_eff),
        .p_limit       (p_limit_reg),
        .rd_addr       (rd_addr),
        .item          (item),
        .k_addr        (k_addr),
        .b_valid       (b_valid)
    );

    // ---------------------------------------------------------------
    // Map memories: the sweep owns the write ports while it runs
    // ---------------------------------------------------------------
    assign sup_ram_we    = sweeping | sup_we;
    assign sup_ram_waddr = sweeping ? sweep_cnt_reg : sup_waddr;
    assign sel_ram_we    = sweeping | sel_we;
    assign sel_ram_waddr = sweeping ? sweep_cnt_reg : sel_waddr;

    ldwc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_MARKERS)
    ) u_sup_map (
        .clk   (clk),
        .we    (sup_ram_we),
        .waddr (sup_ram_waddr),
        .wdata (!sweeping),
        .re    (data_accept),
        .raddr (rd_addr),
        .rdata (sup_rd)
    );

    ldwc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_MARKERS)
    ) u_sel_map (
        .clk   (clk),
        .we    (sel_ram_we),
        .waddr (sel_ram_waddr),
        .wdata (!sweeping),
        .re    (data_accept),
        .raddr (rd_addr),
        .rdata (sel_rd)
    );

    // ---------------------------------------------------------------
    // Decide stage: status, map write-back, result register
    // ---------------------------------------------------------------
    ldwc_decide #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .b_valid      (b_valid),
        .item         (item),
        .k_addr       (k_addr),
        .sup_rd       (sup_rd),
        .sel_rd       (sel_rd),
        .r2_limit     (r2_limit_reg),
        .data_accept  (data_accept),
        .clear_accept (clear_accept),
        .rd_addr      (rd_addr),
        .b_fire       (b_fire),
        .sup_we       (sup_we),
        .sup_waddr    (sup_waddr),
        .sel_we       (sel_we),
        .sel_waddr    (sel_waddr),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

endmodule

// ----- tb/ld_window_clumping_tb.sv -----
`timescale 1ns / 1ps

module ld_window_clumping_tb;
    import ldwc_pkg::*;

    localparam int     CLK_PERIOD     = 12;
    localparam longint TIMEOUT_CYCLES = 2_000_000;
    // Settle wait after the last result, longer than the pipeline depth
    localparam int     SETTLE_CYCLES  = 16;
    localparam int     PHASE_COUNT    = 8;

    // Bit positions of the request fields inside s_tdata
    localparam int P_LSB    = MARKER_W;
    localparam int OFF_LSB  = MARKER_W + P_W;
    localparam int CORR_LSB = MARKER_W + P_W + OFFSET_W;
    localparam int FILL_W   = S_TDATA_W - CORR_LSB - CORR_W;

    // Tracks both bit maps and the open row, and predicts one verdict per
    // closed row; verdicts wait in a queue until the block reports them.
    class clump_tracker;
        typedef struct packed {
            logic [MARKER_W-1:0] marker;
            logic [STATUS_W-1:0] status;
        } verdict_t;

        bit suppressed[int];
        bit selected[int];
        bit row_open;
        bit row_taken;
        logic [STATUS_W-1:0] row_status;
        logic [MARKER_W-1:0] row_marker;

        logic [HW_W-1:0]    half_window;
        logic [P_W-1:0]     p_limit;
        logic [R2_W-1:0]    r2_limit;
        logic [TOTAL_W-1:0] marker_total;

        verdict_t awaited_verdicts[$];
        int errors;
        int requests;
        int clears;
        int verdicts_checked;
        int status_seen[4];

        function new();
            half_window  = HALF_WINDOW_RST;
            p_limit      = P_LIMIT_RST;
            r2_limit     = R2_LIMIT_RST;
            marker_total = MARKER_TOTAL_RST;
            row_open     = 1'b0;
            row_taken    = 1'b0;
            row_status   = STATUS_NEW;
            row_marker   = '0;
        endfunction

        function int unsigned total_eff();
            return (marker_total < MAX_MARKERS_DEF) ? marker_total : MAX_MARKERS_DEF;
        endfunction

        function int unsigned half_eff();
            return (half_window < MAX_HALF_WINDOW) ? half_window : MAX_HALF_WINDOW;
        endfunction

        function void flag(string msg);
            errors++;
            $display("%0t ns: %s", $time, msg);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_HALF_WINDOW:  half_window  = data[HW_W-1:0];
                CFG_P_LIMIT:      p_limit      = data[P_W-1:0];
                CFG_R2_LIMIT:     r2_limit     = data[R2_W-1:0];
                CFG_MARKER_TOTAL: marker_total = data[TOTAL_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_request(logic op, logic [MARKER_W-1:0] marker,
                                   logic [P_W-1:0] p_value, logic [OFFSET_W-1:0] offset,
                                   logic signed [CORR_W-1:0] corr, logic last);
            int unsigned total;
            int unsigned hw;
            longint      k;
            longint      square;
            verdict_t    v;
            requests++;
            total = total_eff();
            hw    = half_eff();
            if (op == OP_CLEAR)
            begin
                suppressed.delete();
                selected.delete();
                row_open  = 1'b0;
                row_taken = 1'b0;
                clears++;
                return;
            end
            // Latch marker and verdict on the first element of a row only
            if (!row_open)
            begin
                row_open   = 1'b1;
                row_marker = marker;
                row_taken  = 1'b0;
                if (marker >= total)
                    row_status = STATUS_P_HIGH;
                else if (suppressed.exists(marker))
                    row_status = STATUS_SUPPRESSED;
                else if (selected.exists(marker))
                    row_status = STATUS_ALREADY;
                else if (p_value >= p_limit)
                    row_status = STATUS_P_HIGH;
                else
                begin
                    row_status = STATUS_NEW;
                    row_taken  = 1'b1;
                    selected[marker] = 1'b1;
                end
            end
            if (row_taken && offset <= 2 * hw)
            begin
                k = longint'(row_marker) - longint'(hw) + longint'(offset);
                if (k >= 0 && k < total && k != row_marker)
                begin
                    square = longint'(corr) * longint'(corr);
                    if (square >= r2_limit)
                        suppressed[int'(k)] = 1'b1;
                end
            end
            if (last)
            begin
                v.marker = row_marker;
                v.status = row_status;
                awaited_verdicts.push_back(v);
                row_open  = 1'b0;
                row_taken = 1'b0;
            end
        endfunction

        function void check_verdict(logic [MARKER_W-1:0] marker, logic [STATUS_W-1:0] status);
            verdict_t want;
            if (awaited_verdicts.size() == 0)
            begin
                flag($sformatf("unexpected result: marker %0d status %0d, nothing awaited",
                               marker, status));
                return;
            end
            want = awaited_verdicts.pop_front();
            verdicts_checked++;
            status_seen[want.status]++;
            if (marker !== want.marker || status !== want.status)
                flag($sformatf("result differs: expected marker %0d status %0d, got %0d / %0d",
                               want.marker, want.status, marker, status));
        endfunction

        function void check_drained();
            verdict_t want;
            while (awaited_verdicts.size() > 0)
            begin
                want = awaited_verdicts.pop_front();
                flag($sformatf("result never arrived: expected marker %0d status %0d",
                               want.marker, want.status));
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // marker_index [15:0], p_value [47:16], window_offset [59:48],
    // correlation [75:60], zero fill [79:76]
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tlast   = 1'b0;  // last_of_row
    logic                   s_tuser   = 1'b0;  // opcode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // result_marker [15:0], status [17:16], zero fill [23:18]
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    clump_tracker tracker;
    int           src_idle_pct  = 0;
    int           sink_stall_pct = 0;
    int           items_sent    = 0;
    int           clears_left   = 4;
    int unsigned  cluster_base  = 0;

    ld_window_clumping DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stall the result side per cycle; a zero rate keeps tready high
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Note the accepted request before checking the result of the same edge,
    // so an answer given at the same edge would still find its expectation in place
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.take_request(s_tuser, s_tdata[MARKER_W-1:0], s_tdata[P_LSB +: P_W],
                                     s_tdata[OFF_LSB +: OFFSET_W],
                                     s_tdata[CORR_LSB +: CORR_W], s_tlast);
            if (m_tvalid && m_tready)
                tracker.check_verdict(m_tdata[MARKER_W-1:0], m_tdata[MARKER_W +: STATUS_W]);
        end
    end

    // Drive one request; hold valid high across back-to-back requests and
    // drop it only for an idle stretch
    task automatic put_request(input logic op, input logic [MARKER_W-1:0] marker,
                               input logic [P_W-1:0] p_value,
                               input logic [OFFSET_W-1:0] offset,
                               input logic [CORR_W-1:0] corr, input logic last);
        @(negedge clk);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {{FILL_W{1'b0}}, corr, offset, p_value, marker};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic put_elem(input logic [MARKER_W-1:0] marker, input logic [P_W-1:0] p_value,
                            input logic [OFFSET_W-1:0] offset, input logic [CORR_W-1:0] corr,
                            input logic last);
        put_request(OP_CORR, marker, p_value, offset, corr, last);
    endtask

    task automatic put_clear();
        put_request(OP_CLEAR, MARKER_W'($urandom), $urandom,
                    OFFSET_W'($urandom_range(0, 4095)), CORR_W'($urandom),
                    1'($urandom_range(1)));
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Close a row left open by a broken sequence so the block sits between rows
    task automatic close_row();
        end_burst();
        if (tracker.row_open)
        begin
            put_elem(MARKER_W'($urandom), $urandom, OFFSET_W'($urandom_range(0, 4095)),
                     CORR_W'($urandom), 1'b1);
            end_burst();
        end
    endtask

    // Hold off until every awaited result is in, then let the pipeline settle
    task automatic drain();
        while (tracker.awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] hw, input logic [31:0] p_lim,
                             input logic [31:0] r2_lim, input logic [31:0] total);
        write_reg(CFG_HALF_WINDOW, hw);
        write_reg(CFG_P_LIMIT, p_lim);
        write_reg(CFG_R2_LIMIT, r2_lim);
        write_reg(CFG_MARKER_TOTAL, total);
    endtask

    // Keep markers close together so rows interact through the maps
    function automatic logic [MARKER_W-1:0] pick_marker();
        int unsigned total;
        int unsigned m;
        total = tracker.total_eff();
        if ($urandom_range(9) == 0)
            return MARKER_W'($urandom);
        if (total <= 256)
            m = $urandom_range(0, total + 2);
        else
            m = cluster_base + $urandom_range(0, 64);
        if (m > 65535)
            m = 65535;
        return m[MARKER_W-1:0];
    endfunction

    // Bias toward the threshold itself and just under it
    function automatic logic [P_W-1:0] pick_p();
        case ($urandom_range(9))
            0:       return tracker.p_limit;
            1:       return tracker.p_limit - 1;
            2, 3:    return $urandom;
            4, 5, 6: return $urandom_range(0, tracker.p_limit);
            default: return $urandom_range(0, 32'h3F80_0000);
        endcase
    endfunction

    function automatic logic [CORR_W-1:0] pick_corr();
        logic [CORR_W-1:0] c;
        case ($urandom_range(7))
            0:       c = 16'h8000;
            1:       c = 16'h7FFF;
            2, 3:
            begin
                c = CORR_W'($urandom_range(0, 4000));
                if ($urandom_range(1))
                    c = -c;
            end
            default: c = CORR_W'($urandom);
        endcase
        return c;
    endfunction

    // Send one row: well-formed rows walk the window in order with one marker
    // and p-value on the first element; broken rows jump anywhere in the
    // offset range and may leave the row open
    task automatic send_row(input bit well_formed);
        int unsigned       hw;
        int unsigned       span;
        int unsigned       off;
        int unsigned       stride_max;
        int unsigned       lo;
        int                n;
        int                offs[$];
        logic [MARKER_W-1:0] row_m;
        logic [P_W-1:0]      row_p;
        logic [MARKER_W-1:0] m;
        logic [P_W-1:0]      p;
        logic                last;
        hw    = tracker.half_eff();
        span  = 2 * hw;
        row_m = pick_marker();
        row_p = pick_p();
        if (well_formed)
        begin
            if (span <= 12)
            begin
                for (int i = 0; i <= span; i++)
                    offs.push_back(i);
            end
            else
            begin
                // Wide windows: a short sparse walk, often around the marker itself
                n  = $urandom_range(1, 10);
                lo = (hw > 32) ? hw - 32 : 0;
                if ($urandom_range(1))
                begin
                    off        = $urandom_range(lo, hw);
                    stride_max = 8;
                end
                else
                begin
                    off        = $urandom_range(0, span / 4);
                    stride_max = span / 4;
                end
                while (offs.size() < n && off <= span)
                begin
                    offs.push_back(off);
                    off += $urandom_range(1, stride_max);
                end
                if ($urandom_range(3) == 0)
                    offs.push_back(span);
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) offs.push_back($urandom_range(0, 4095));
        end
        foreach (offs[i])
        begin
            m = row_m;
            p = row_p;
            // Later elements carry junk in the latched fields now and then
            if (i > 0 && $urandom_range(1))
            begin
                m = MARKER_W'($urandom);
                p = $urandom;
            end
            last = (i == offs.size() - 1) && (well_formed || $urandom_range(2) != 0);
            put_elem(m, p, OFFSET_W'(offs[i]), pick_corr(), last);
        end
    endtask

    task automatic send_noise();
        if (clears_left > 0 && $urandom_range(7) == 0)
        begin
            clears_left--;
            put_clear();
        end
        else
            put_elem(MARKER_W'($urandom), $urandom, OFFSET_W'($urandom_range(0, 4095)),
                     CORR_W'($urandom), 1'($urandom_range(1)));
    endtask

    // Hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int budget[PHASE_COUNT];
        int target;
        int pick;
        budget  = '{210, 210, 210, 210, 210, 60, 210, 210};
        tracker = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows; writes land while the map sweep after reset runs
        configure(2, P_LIMIT_RST, R2_LIMIT_RST, 8);
        // Marker 3 taken: suppress 1, 2 and 5, skip itself, spare 4
        put_elem(3, 32'h3C00_0000, 0, 16'h8000, 1'b0);
        put_elem(3, 32'h3C00_0000, 1, 16'h7FFF, 1'b0);
        put_elem(3, 32'h3C00_0000, 2, 16'h8000, 1'b0);
        put_elem(3, 32'h3C00_0000, 3, 16'd100, 1'b0);
        put_elem(3, 32'h3C00_0000, 4, -16'sd20000, 1'b1);
        put_elem(1, 0, 0, 0, 1'b1);                     // suppressed
        put_elem(3, 0, 0, 0, 1'b1);                     // already selected
        put_elem(4, 32'h8000_0000, 0, 0, 1'b1);         // negative zero p
        put_elem(6, 32'hFFFF_FFFF, 0, 0, 1'b1);         // NaN pattern p
        put_elem(16'hFFFF, 0, 0, 0, 1'b1);              // marker out of range
        // Lower edge: negative neighbors, offsets past the row
        put_elem(0, 0, 0, 16'h7FFF, 1'b0);
        put_elem(0, 0, 12'hFFF, 16'h7FFF, 1'b0);
        put_elem(0, 0, 5, 16'h8000, 1'b0);
        put_elem(0, 0, 4, 16'h7FFF, 1'b1);
        // Upper edge: neighbors at and past the marker total
        put_elem(7, 0, 3, 16'h8000, 1'b0);
        put_elem(7, 0, 4, 16'h8000, 1'b1);
        // Abandon an open row with a clear
        put_elem(6, 0, 0, 16'h8000, 1'b0);
        put_clear();
        put_elem(1, 0, 0, 0, 1'b1);                     // newly selected again
        put_elem(3, 0, 1, 16'h8000, 1'b1);              // suppresses 2 before its own row
        put_elem(2, 0, 0, 0, 1'b1);
        put_elem(3, 0, 0, 16'h8000, 1'b1);              // already selected
        put_elem(6, P_LIMIT_RST, 0, 0, 1'b1);           // p equal to limit
        put_elem(5, P_LIMIT_RST - 1, 0, 0, 1'b1);       // p just under limit
        end_burst();
        // Pause the sender until every result is in
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: configure(3, 32'h3F00_0000, R2_LIMIT_RST, 48);
                1: configure(0, 32'hFFFF_FFFF, 0, 24);
                2: configure(MAX_HALF_WINDOW, $urandom, 32'h4000_0000, MAX_MARKERS_DEF);
                3: configure(11'h7FF, P_LIMIT_RST, R2_LIMIT_RST, 65535);
                4: configure(5, 0, $urandom_range(0, 32'h4000_0000), 1);
                5: configure(2, 32'h3F80_0000, 32'h7FFF_FFFF, 0);
                6: configure($urandom_range(1, 8), $urandom, $urandom_range(0, 32'h4000_0000),
                             17'h1FFFF);
                default: configure(4, 32'h3E00_0000, R2_LIMIT_RST / 4, 64);
            endcase
            case (ph % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 83; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 83; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            if (tracker.total_eff() > 256)
                cluster_base = $urandom_range(1) ? tracker.total_eff() - 40
                                                 : $urandom_range(0, tracker.total_eff() - 1);
            target = items_sent + budget[ph];
            while (items_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    send_row(1'b1);
                else if (pick < 90)
                    send_row(1'b0);
                else
                    send_noise();
            end
            close_row();
            drain();
        end

        tracker.check_drained();
        $display("Covered %0d requests with %0d map clears over %0d settings; %0d results:",
                 tracker.requests, tracker.clears, PHASE_COUNT + 1, tracker.verdicts_checked);
        $display("  %0d new, %0d suppressed, %0d already selected, %0d high p or out of range",
                 tracker.status_seen[STATUS_NEW], tracker.status_seen[STATUS_SUPPRESSED],
                 tracker.status_seen[STATUS_ALREADY], tracker.status_seen[STATUS_P_HIGH]);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- ld_window_clumping.f -----
src/ldwc_pkg.sv
src/ldwc_ram.sv
src/ldwc_front.sv
src/ldwc_decide.sv
src/ld_window_clumping.sv
tb/ld_window_clumping_tb.sv
